[rtl/core/dmodf_pkg.sv]
// package for double_modf_split: field widths, exponent constants, stage control struct
// no dependencies
package dmodf_pkg;

	localparam int unsigned DataW = 64;
	localparam int unsigned MantW = 52;
	localparam int unsigned ExpW  = 11;
	localparam int unsigned PosW  = 6;
	localparam logic [ExpW-1:0] ExpAll  = 11'h7ff;
	localparam logic [ExpW-1:0] ExpBias = 11'h3ff;
	localparam logic [ExpW:0]   ExpTop  = 12'h400;

	typedef enum logic [3:0] {
		K_PASS  = 4'b0001,
		K_SMALL = 4'b0010,
		K_WHOLE = 4'b0100,
		K_SPLIT = 4'b1000
	} kind_t;

	typedef struct packed {
		logic [DataW-1:0] x;
		kind_t            kind;
		logic [PosW-1:0]  e;
		logic [MantW-1:0] f;
	} stage_t;

endpackage

[rtl/core/dmodf_norm.sv]
// fraction normalizer: leading-one search over the masked fraction, then shift and pack
// depends on dmodf_pkg; two register stages under an external enable
module dmodf_norm (
	input  logic                 clk,
	input  logic                 en,
	input  dmodf_pkg::stage_t    in_s,
	output logic [dmodf_pkg::DataW-1:0] int_part,
	output logic [dmodf_pkg::DataW-1:0] frac_part
);

	dmodf_pkg::stage_t               st_s2;
	logic [dmodf_pkg::PosW-1:0]      p_s2;
	logic [dmodf_pkg::PosW-1:0]      p_c;
	logic [dmodf_pkg::MantW-1:0]     mask_c;
	logic [dmodf_pkg::MantW-1:0]     sh_c;
	logic [dmodf_pkg::ExpW-1:0]      ex_c;
	logic                            sgn_c;

	always_comb begin
		p_c = '0;
		for (int i = 0; i < dmodf_pkg::MantW; i++) begin
			if (in_s.f[i]) begin
				p_c = dmodf_pkg::PosW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s2 <= in_s;
			p_s2  <= p_c;
		end
	end

	always_comb begin
		sgn_c  = st_s2.x[dmodf_pkg::DataW-1];
		mask_c = {dmodf_pkg::MantW{1'b1}} >> st_s2.e;
		sh_c   = st_s2.f << (dmodf_pkg::PosW'(dmodf_pkg::MantW) - p_s2);
		ex_c   = dmodf_pkg::ExpW'(p_s2) + dmodf_pkg::ExpW'(st_s2.e)
		         + dmodf_pkg::ExpBias - dmodf_pkg::ExpW'(dmodf_pkg::MantW);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (st_s2.kind)
				dmodf_pkg::K_PASS: begin
					int_part  <= st_s2.x;
					frac_part <= st_s2.x;
				end
				dmodf_pkg::K_SMALL: begin
					int_part  <= {sgn_c, 63'd0};
					frac_part <= st_s2.x;
				end
				dmodf_pkg::K_WHOLE: begin
					int_part  <= st_s2.x;
					frac_part <= {sgn_c, 63'd0};
				end
				dmodf_pkg::K_SPLIT: begin
					int_part  <= {st_s2.x[dmodf_pkg::DataW-1:dmodf_pkg::MantW],
					              st_s2.x[dmodf_pkg::MantW-1:0] & ~mask_c};
					frac_part <= {sgn_c, ex_c, sh_c};
				end
				default: begin
					int_part  <= st_s2.x;
					frac_part <= st_s2.x;
				end
			endcase
		end
	end

endmodule

[rtl/core/double_modf_split.sv]
// top level of double_modf_split: stream pipeline splitting a double into integral and fraction
// depends on dmodf_pkg and dmodf_norm
//
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | x_bits[63:0]
// m_axis  | out | int_part[63:0], frac_part[127:64]
//
// one beat per cycle unless the output stalls; registered stages in order: classify, leading-one search, pack
// the pipeline advances whenever the output register is empty or taken
// arst_n clears the valid bits only; payload registers carry no reset
// a stall freezes all stages in place, nothing lost or repeated
module double_modf_split (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [63:0]   s_axis_tdata,   // x_bits
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [127:0]  m_axis_tdata    // int_part, frac_part
);

	dmodf_pkg::stage_t st_s1;
	dmodf_pkg::stage_t st_c;
	logic              v_s1, v_s2, v_s3;
	logic              en;
	logic [dmodf_pkg::ExpW-1:0]  ebits_c;
	logic [dmodf_pkg::ExpW:0]    e_c;
	logic [dmodf_pkg::MantW-1:0] fmask_c;
	logic [63:0]                 int_part;
	logic [63:0]                 frac_part;

	assign en            = !v_s3 || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = {frac_part, int_part};

	always_comb begin
		ebits_c = s_axis_tdata[62:52];
		e_c     = {1'b0, ebits_c} - {1'b0, dmodf_pkg::ExpBias};
		fmask_c = {dmodf_pkg::MantW{1'b1}} >> e_c[dmodf_pkg::PosW-1:0];
		st_c.x  = s_axis_tdata;
		st_c.e  = e_c[dmodf_pkg::PosW-1:0];
		st_c.f  = s_axis_tdata[51:0] & fmask_c;
		if (ebits_c == dmodf_pkg::ExpAll && s_axis_tdata[51:0] != '0) begin
			st_c.kind = dmodf_pkg::K_PASS;
		end else if (ebits_c >= 11'd1075) begin
			st_c.kind = dmodf_pkg::K_WHOLE;
		end else if (ebits_c < dmodf_pkg::ExpBias) begin
			st_c.kind = dmodf_pkg::K_SMALL;
		end else if (st_c.f == '0) begin
			st_c.kind = dmodf_pkg::K_WHOLE;
		end else begin
			st_c.kind = dmodf_pkg::K_SPLIT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= st_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	dmodf_norm u_norm (
		.clk       (clk),
		.en        (en),
		.in_s      (st_s1),
		.int_part  (int_part),
		.frac_part (frac_part)
	);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !m_axis_tready) |=> (v_s3 && $stable(m_axis_tdata)))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s3 |-> s_axis_tready)
		else $error("input stalled with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tready && v_s2) |=> v_s3)
		else $error("beat lost in pipeline");

endmodule
